// ===== rtl/banked_gpio_masked_write_regs_core_defines.svh =====
// Assertion macros used by the checker file of the banked GPIO register block.
`ifndef BANKED_GPIO_MASKED_WRITE_REGS_CORE_DEFINES_SVH
`define BANKED_GPIO_MASKED_WRITE_REGS_CORE_DEFINES_SVH

// Concurrent assertion on the rising edge of clk, switched off while rst is high.
`define BGPIO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the rising edge of clk that also holds during reset.
`define BGPIO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bgpio_pkg.sv =====
// Package with the constants, types and helper functions of the banked GPIO register block.
package bgpio_pkg;

  localparam int NUM_BANKS  = 6;
  localparam int BANK_WIDTH = 32;
  localparam int BANK_IDX_W = $clog2(NUM_BANKS);
  localparam int HALF_BITS  = 16;

  // Bank widths that are narrower than a full bank.
  localparam int WIDTH_NARROW = 26;
  localparam int WIDTH_SHORT  = 22;

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Register selects.
  localparam logic [2:0] REG_MASK_LO = 3'd0;
  localparam logic [2:0] REG_MASK_HI = 3'd1;
  localparam logic [2:0] REG_DATA    = 3'd2;
  localparam logic [2:0] REG_PAD     = 3'd3;
  localparam logic [2:0] REG_DIR     = 3'd4;
  localparam logic [2:0] REG_OE      = 3'd5;

  typedef logic [BANK_WIDTH-1:0] bank_word_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  bank;
    logic [2:0]  reg_sel;
    logic [31:0] wdata;
    logic [31:0] pad_in;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [31:0] pad_out;
    logic [31:0] pad_drive;
    logic        error;
  } rsp_t;

  // Number of banks that the variant provides, never more than are built.
  function automatic logic [3:0] bank_count(input logic variant);
    logic [3:0] n;
    n = variant ? 4'd4 : 4'd6;
    if (n > 4'(NUM_BANKS)) begin
      n = 4'(NUM_BANKS);
    end
    return n;
  endfunction

  // Mask of the bits that exist in a bank under the given variant.
  function automatic bank_word_t width_mask(input logic variant, input logic [2:0] bank);
    int w;
    if (variant) begin
      w = (bank == 3'd1) ? WIDTH_SHORT : 32;
    end else begin
      w = (bank < 3'd3) ? WIDTH_NARROW : 32;
    end
    if (w >= BANK_WIDTH) begin
      return '1;
    end
    return BANK_WIDTH'((64'd1 << w) - 64'd1);
  endfunction

  // Masked half-word update: a mask bit of 0 lets the data bit beside it through.
  // The inverted mask is formed at half width so that the other half stays untouched.
  function automatic bank_word_t masked_half(input bank_word_t old_val,
                                             input logic [31:0] word,
                                             input logic high);
    logic [HALF_BITS-1:0] keep;
    bank_word_t sel;
    bank_word_t dat;
    keep = ~word[31:HALF_BITS];
    sel  = BANK_WIDTH'(keep);
    dat  = BANK_WIDTH'(word[HALF_BITS-1:0]);
    if (high) begin
      sel = sel << HALF_BITS;
      dat = dat << HALF_BITS;
    end
    return (old_val & ~sel) | (dat & sel);
  endfunction

endpackage

// ===== rtl/bgpio_if.sv =====
// Valid/ready channel interfaces for bus access words and result words.
interface bgpio_req_if import bgpio_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  bank;
  logic [2:0]  reg_sel;
  logic [31:0] wdata;
  logic [31:0] pad_in;

  modport source (output valid, output cmd, output bank, output reg_sel, output wdata,
                  output pad_in, input ready);
  modport sink (input valid, input cmd, input bank, input reg_sel, input wdata,
                input pad_in, output ready);
endinterface

interface bgpio_rsp_if import bgpio_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic [31:0] pad_out;
  logic [31:0] pad_drive;
  logic        error;

  modport source (output valid, output rdata, output pad_out, output pad_drive,
                  output error, input ready);
  modport sink (input valid, input rdata, input pad_out, input pad_drive,
                input error, output ready);
endinterface

// ===== rtl/banked_gpio_masked_write_regs_core.sv =====
// Banked GPIO register block: each bus access word reads or writes one register of one bank
// and returns one result word. Every bank holds an output latch, a direction register
// (1 = output) and an output enable; the two masked registers update the low or high half
// of the latch, with the upper 16 bits of the write word acting as a mask where a 0 lets
// the data bit beside it through. The variant register picks six banks of widths
// 26,26,26,32,32,32 or four banks of widths 32,22,32,32; bits beyond a bank's width read
// as zero. A bank beyond the variant's count or an unknown register select sets the error
// flag and changes nothing. The block takes one access word per cycle while the result
// channel is not stalled; each access passes through the input register, where the decode
// and the register file update happen, and then through the result register. Backpressure on
// the result channel holds both stages, and the input side keeps accepting as long as the
// input register can move on. The variant may only be written while no access is in flight.
module banked_gpio_masked_write_regs_core
  import bgpio_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  bgpio_req_if.sink    req,
  bgpio_rsp_if.source  rsp
);

  // Configuration.
  logic variant;

  // Register file, one entry per bank.
  bank_word_t out_latch  [NUM_BANKS];
  bank_word_t direction  [NUM_BANKS];
  bank_word_t out_enable [NUM_BANKS];

  // Input register.
  logic s1_valid;
  req_t s1_req;

  // Result register.
  logic rsp_valid;
  rsp_t rsp_word;

  logic advance;
  logic bank_ok;
  logic reg_ok;
  logic do_write;
  logic [BANK_IDX_W-1:0] idx;
  bank_word_t m;
  bank_word_t cur_latch;
  bank_word_t cur_dir;
  bank_word_t cur_oe;
  bank_word_t latch_next;
  bank_word_t direction_next;
  bank_word_t out_enable_next;
  bank_word_t rd;
  rsp_t rsp_next;

  // The input register moves on whenever the result register is empty or being drained.
  assign advance   = !rsp_valid || rsp.ready;
  assign req.ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= 1'b0;
    end else if (cfg_we) begin
      variant <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req.cmd     <= req.cmd;
      s1_req.bank    <= req.bank;
      s1_req.reg_sel <= req.reg_sel;
      s1_req.wdata   <= req.wdata;
      s1_req.pad_in  <= req.pad_in;
    end
  end

  // Decode of the access held in the input register. The bank index is only used when the
  // bank check passes, which keeps it below the number of built banks.
  always_comb begin
    bank_ok   = {1'b0, s1_req.bank} < bank_count(variant);
    idx       = s1_req.bank[BANK_IDX_W-1:0];
    m         = width_mask(variant, s1_req.bank);
    reg_ok    = s1_req.reg_sel inside {[REG_MASK_LO:REG_OE]};
    cur_latch = out_latch[idx];
    cur_dir   = direction[idx];
    cur_oe    = out_enable[idx];
    do_write  = s1_valid && bank_ok && reg_ok && (s1_req.cmd == CMD_WRITE);

    latch_next      = cur_latch;
    direction_next  = cur_dir;
    out_enable_next = cur_oe;
    if (s1_req.cmd == CMD_WRITE) begin
      case (s1_req.reg_sel)
        REG_MASK_LO: begin
          latch_next = masked_half(cur_latch, s1_req.wdata, 1'b0) & m;
        end
        REG_MASK_HI: begin
          latch_next = masked_half(cur_latch, s1_req.wdata, 1'b1) & m;
        end
        REG_DATA: begin
          latch_next = s1_req.wdata & m;
        end
        REG_DIR: begin
          direction_next = s1_req.wdata & m;
        end
        REG_OE: begin
          out_enable_next = s1_req.wdata & m;
        end
        default: begin
        end
      endcase
    end

    // Reads; the masked half registers are write-only and read as zero.
    rd = '0;
    if (s1_req.cmd == CMD_READ) begin
      case (s1_req.reg_sel)
        REG_DATA: begin
          rd = cur_latch & m;
        end
        REG_PAD: begin
          rd = s1_req.pad_in & m;
        end
        REG_DIR: begin
          rd = cur_dir & m;
        end
        REG_OE: begin
          rd = cur_oe & m;
        end
        default: begin
          rd = '0;
        end
      endcase
    end

    if (!bank_ok) begin
      rsp_next = '{rdata: '0, pad_out: '0, pad_drive: '0, error: 1'b1};
    end else if (!reg_ok) begin
      // Unknown register: nothing changes, but the bank's pins are still reported.
      rsp_next.rdata     = '0;
      rsp_next.pad_out   = cur_latch & m;
      rsp_next.pad_drive = cur_dir & cur_oe & m;
      rsp_next.error     = 1'b1;
    end else begin
      rsp_next.rdata     = rd;
      rsp_next.pad_out   = latch_next & m;
      rsp_next.pad_drive = direction_next & out_enable_next & m;
      rsp_next.error     = 1'b0;
    end
  end

  // The register file is updated at the same edge that moves the access to the result
  // register, so the next access in the input register already sees the new contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        out_latch[i]  <= '0;
        direction[i]  <= '0;
        out_enable[i] <= '0;
      end
    end else if (advance && do_write) begin
      out_latch[idx]  <= latch_next;
      direction[idx]  <= direction_next;
      out_enable[idx] <= out_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp_word <= rsp_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.rdata     = rsp_word.rdata;
  assign rsp.pad_out   = rsp_word.pad_out;
  assign rsp.pad_drive = rsp_word.pad_drive;
  assign rsp.error     = rsp_word.error;

endmodule

// ===== rtl/bgpio_checker.sv =====
// Port-level assertion checker for the banked GPIO register block and its bind statement.
`include "banked_gpio_masked_write_regs_core_defines.svh"

module bgpio_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_rdata,
  input logic        rsp_error
);

  // A pending result word is not withdrawn before it is taken.
  `BGPIO_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result word withdrawn")

  // A result word that appears on an idle output stems from an accepted access word.
  `BGPIO_ASSERT(a_rsp_latency, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "result without access")

  // The result channel only drains when the sink has taken the word.
  `BGPIO_ASSERT(a_rsp_drain, $fell(rsp_valid) |-> $past(rsp_ready), "result word lost")

  // A rejected access never returns read data.
  `BGPIO_ASSERT(a_err_rdata, rsp_valid && rsp_error |-> rsp_rdata == 32'd0, "read data on error")

  // No access is taken while reset is applied.
  `BGPIO_ASSERT_ALWAYS(a_rst_ready, rst |-> !req_ready, "ready during reset")

endmodule

bind banked_gpio_masked_write_regs_core bgpio_checker u_bgpio_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_rdata (rsp.rdata),
  .rsp_error (rsp.error)
);
